@@ hw/rtl/xrfri_pkg.sv @@
// shared types and constants for the pixel roi integrator
// field widths, operation and result codes, queue item layout
// no dependencies
`timescale 1ns / 1ps

package xrfri_pkg;

	// fixed field widths of the ports
	localparam int OP_W       = 3;
	localparam int DATUM_W    = 28;
	localparam int COORD_W    = 12;
	localparam int BIN_W      = 14;
	localparam int ROI_W      = 14;
	localparam int KIND_W     = 2;
	localparam int VALUE_W    = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	// parameter defaults
	localparam int BIN_BITS_DEF   = 14;
	localparam int COUNT_BITS_DEF = 14;
	localparam int ACC_BITS_DEF   = 32;
	localparam int COORD_BITS_DEF = 12;

	// roi bound reset values
	localparam logic [ROI_W-1:0] ROI_LOWER_RST = 14'd0;
	localparam logic [ROI_W-1:0] ROI_UPPER_RST = 14'h3FFF;

	typedef enum logic [OP_W-1:0] {
		OP_DATUM  = 3'd0,
		OP_HEADER = 3'd1,
		OP_FINISH = 3'd2,
		OP_READ   = 3'd3,
		OP_START  = 3'd4
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_SUMMARY = 2'd1,
		KIND_BIN     = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROI_LOWER = 1'd0,
		REG_ROI_UPPER = 1'd1
	} reg_idx_t;

	// classified beat as it travels through the queue
	typedef struct packed {
		op_t                op;
		logic               in_roi;
		logic [DATUM_W-1:0] datum_word;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [BIN_W-1:0]   read_bin;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ hw/rtl/xrf_pixel_roi_integrator_core.sv @@
// top level of the pixel roi integrator: front end, queue, back end
// result path: queue slot, then result register (read: histogram read register between)
// back end: datum beats read their histogram bin, then write it back; read beats read a
// bin; header and finish use no memory, start reruns the clear pass; a busy output stalls
// reset: control clears at once, then a pass over all 2**BIN_BITS bins (16384 by default)
// zeroes the histogram; input beats wait, configuration writes are taken
`timescale 1ns / 1ps

module xrf_pixel_roi_integrator_core import xrfri_pkg::*; #(
	parameter int BIN_BITS   = BIN_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int ACC_BITS   = ACC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input beats
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic [OP_W-1:0]       operation,
	input  logic [DATUM_W-1:0]    datum_word,
	input  logic [COORD_W-1:0]    pixel_x,
	input  logic [COORD_W-1:0]    pixel_y,
	input  logic [BIN_W-1:0]      read_bin,
	// result beats
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [KIND_W-1:0]     result_kind,
	output logic [COORD_W-1:0]    closed_x,
	output logic [COORD_W-1:0]    closed_y,
	output logic [VALUE_W-1:0]    value,
	output logic [VALUE_W-1:0]    min_integral,
	output logic [VALUE_W-1:0]    max_integral
);

	// front to queue
	logic      push;
	item_t     push_item;
	// queue to back
	item_t     head;
	q_status_t q_status;
	logic      pop;
	// back end is zeroing the histogram, front holds off new beats
	logic      clearing;

	// front: roi bounds live here, so the roi test is done once per beat
	xrfri_front #(
		.BIN_BITS  (BIN_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation (operation),
		.datum_word(datum_word),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.read_bin  (read_bin),
		.q_status  (q_status),
		.clearing  (clearing),
		.push      (push),
		.push_item (push_item)
	);

	// short queue so the input keeps flowing while a result waits
	xrfri_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	// back: histogram read-modify-write, pixel close, statistics, result register
	xrfri_back #(
		.BIN_BITS  (BIN_BITS),
		.COUNT_BITS(COUNT_BITS),
		.ACC_BITS  (ACC_BITS),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.clearing    (clearing),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_kind (result_kind),
		.closed_x    (closed_x),
		.closed_y    (closed_y),
		.value       (value),
		.min_integral(min_integral),
		.max_integral(max_integral)
	);

endmodule

@@ hw/rtl/xrfri_front.sv @@
// front end: roi bound registers, input acceptance and classification
// depends on xrfri_pkg
`timescale 1ns / 1ps

module xrfri_front import xrfri_pkg::*; #(
	parameter int BIN_BITS   = BIN_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic [OP_W-1:0]       operation,
	input  logic [DATUM_W-1:0]    datum_word,
	input  logic [COORD_W-1:0]    pixel_x,
	input  logic [COORD_W-1:0]    pixel_y,
	input  logic [BIN_W-1:0]      read_bin,
	input  q_status_t             q_status,
	input  logic                  clearing,
	output logic                  push,
	output item_t                 push_item
);

	localparam int CMP_BITS = (BIN_BITS > ROI_W) ? BIN_BITS : ROI_W;

	logic [ROI_W-1:0]    roi_lo_q;
	logic [ROI_W-1:0]    roi_hi_q;
	logic [BIN_BITS-1:0] bin;
	logic                known_op;
	op_t                 op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_lo_q <= ROI_LOWER_RST;
			roi_hi_q <= ROI_UPPER_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_ROI_LOWER) roi_lo_q <= ROI_W'(cfg_data);
			if (cfg_index == REG_ROI_UPPER) roi_hi_q <= ROI_W'(cfg_data);
		end
	end

	assign op  = op_t'(operation);
	assign bin = BIN_BITS'(datum_word >> COUNT_BITS);

	always_comb begin
		case (op)
			OP_DATUM, OP_HEADER, OP_FINISH, OP_READ, OP_START: known_op = 1'b1;
			default: known_op = 1'b0;
		endcase
	end

	// unknown codes are taken and dropped here
	assign item_ready = !q_status.full && !clearing;
	assign push       = item_valid && item_ready && known_op;

	always_comb begin
		push_item.op         = op;
		push_item.in_roi     = (CMP_BITS'(bin) > CMP_BITS'(roi_lo_q)) &&
		                       (CMP_BITS'(bin) < CMP_BITS'(roi_hi_q));
		push_item.datum_word = datum_word;
		push_item.pixel_x    = pixel_x;
		push_item.pixel_y    = pixel_y;
		push_item.read_bin   = read_bin;
	end

endmodule

@@ hw/rtl/xrfri_queue.sv @@
// two-entry queue between front and back ends
// depends on xrfri_pkg
`timescale 1ns / 1ps

module xrfri_queue import xrfri_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_t     push_item,
	input  logic      pop,
	output item_t     head,
	output q_status_t status
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign head         = slot_q[rd_ptr_q];
	assign status.full  = cnt_q[1];
	assign status.empty = (cnt_q == 2'd0);

endmodule

@@ hw/rtl/xrfri_back.sv @@
// back end: histogram memory, pixel integral, statistics and result register
// depends on xrfri_pkg
`timescale 1ns / 1ps

module xrfri_back import xrfri_pkg::*; #(
	parameter int BIN_BITS   = BIN_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	parameter int ACC_BITS   = ACC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  item_t              head,
	input  q_status_t          q_status,
	output logic               pop,
	output logic               clearing,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [KIND_W-1:0]  result_kind,
	output logic [COORD_W-1:0] closed_x,
	output logic [COORD_W-1:0] closed_y,
	output logic [VALUE_W-1:0] value,
	output logic [VALUE_W-1:0] min_integral,
	output logic [VALUE_W-1:0] max_integral
);

	localparam int HIST_DEPTH = 1 << BIN_BITS;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DATUM_WR,
		ST_READ_WAIT
	} state_t;

	function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
	                                                input logic [COUNT_BITS-1:0] b);
		logic [ACC_BITS:0] sum;
		sum = {1'b0, a} + (ACC_BITS+1)'(b);
		return sum[ACC_BITS] ? {ACC_BITS{1'b1}} : sum[ACC_BITS-1:0];
	endfunction

	logic [ACC_BITS-1:0] hist_mem [HIST_DEPTH];
	logic [ACC_BITS-1:0] rdata_q;

	state_t              state_q;
	logic [BIN_BITS-1:0] clr_q;
	logic [BIN_BITS-1:0] bin_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                open_flag_q;
	logic [COORD_BITS-1:0] open_x_q;
	logic [COORD_BITS-1:0] open_y_q;
	logic [ACC_BITS-1:0] integral_q;
	logic [ACC_BITS-1:0] min_q;
	logic [ACC_BITS-1:0] max_q;
	logic                closed_any_q;

	logic                out_valid_q;
	kind_t               out_kind_q;
	logic [COORD_W-1:0]  out_x_q;
	logic [COORD_W-1:0]  out_y_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic [VALUE_W-1:0]  out_min_q;
	logic [VALUE_W-1:0]  out_max_q;

	logic                out_free;
	logic                out_load;
	logic [BIN_BITS-1:0] h_bin;
	logic [COUNT_BITS-1:0] h_cnt;
	logic [ACC_BITS-1:0] new_min;
	logic [ACC_BITS-1:0] new_max;
	logic                mem_re;
	logic [BIN_BITS-1:0] mem_raddr;
	logic                mem_we;
	logic [BIN_BITS-1:0] mem_waddr;
	logic [ACC_BITS-1:0] mem_wdata;

	assign out_free = !out_valid_q || result_ready;
	assign h_bin    = BIN_BITS'(head.datum_word >> COUNT_BITS);
	assign h_cnt    = COUNT_BITS'(head.datum_word);
	assign new_min  = (integral_q < min_q) ? integral_q : min_q;
	assign new_max  = (integral_q > max_q) ? integral_q : max_q;
	assign clearing = (state_q == ST_CLEAR);

	// pop decision, finish and a closing header wait for a free result slot
	always_comb begin
		pop = 1'b0;
		if (state_q == ST_IDLE && !q_status.empty) begin
			case (head.op)
				OP_HEADER: pop = !open_flag_q || out_free;
				OP_FINISH: pop = out_free;
				default:   pop = 1'b1;
			endcase
		end
	end

	// result register loads on a closing header, a finish or a finished read
	always_comb begin
		case (state_q)
			ST_IDLE: out_load = pop && (head.op == OP_FINISH ||
			                            (head.op == OP_HEADER && open_flag_q));
			ST_READ_WAIT: out_load = out_free;
			default: out_load = 1'b0;
		endcase
	end

	always_comb begin
		mem_re    = pop && (head.op == OP_DATUM || head.op == OP_READ);
		mem_raddr = (head.op == OP_READ) ? BIN_BITS'(head.read_bin) : h_bin;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_DATUM_WR: begin
				mem_we    = 1'b1;
				mem_waddr = bin_q;
				mem_wdata = sat_add(rdata_q, cnt_q);
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_re) rdata_q <= hist_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			bin_q        <= '0;
			cnt_q        <= '0;
			open_flag_q  <= 1'b0;
			open_x_q     <= '0;
			open_y_q     <= '0;
			integral_q   <= '0;
			min_q        <= '1;
			max_q        <= '0;
			closed_any_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_PIXEL;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_value_q  <= '0;
			out_min_q    <= '0;
			out_max_q    <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + BIN_BITS'(1);
					if (&clr_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop) begin
						case (head.op)
							OP_DATUM: begin
								bin_q   <= h_bin;
								cnt_q   <= h_cnt;
								state_q <= ST_DATUM_WR;
								if (open_flag_q && head.in_roi)
									integral_q <= sat_add(integral_q, h_cnt);
							end
							OP_HEADER: begin
								if (open_flag_q) begin
									out_kind_q   <= KIND_PIXEL;
									out_x_q      <= COORD_W'(open_x_q);
									out_y_q      <= COORD_W'(open_y_q);
									out_value_q  <= VALUE_W'(integral_q);
									out_min_q    <= VALUE_W'(new_min);
									out_max_q    <= VALUE_W'(new_max);
									min_q        <= new_min;
									max_q        <= new_max;
									closed_any_q <= 1'b1;
								end
								open_flag_q <= 1'b1;
								open_x_q    <= COORD_BITS'(head.pixel_x);
								open_y_q    <= COORD_BITS'(head.pixel_y);
								integral_q  <= '0;
							end
							OP_FINISH: begin
								out_kind_q  <= KIND_SUMMARY;
								if (open_flag_q) begin
									out_x_q      <= COORD_W'(open_x_q);
									out_y_q      <= COORD_W'(open_y_q);
									out_value_q  <= VALUE_W'(integral_q);
									out_min_q    <= VALUE_W'(new_min);
									out_max_q    <= VALUE_W'(new_max);
									min_q        <= new_min;
									max_q        <= new_max;
									closed_any_q <= 1'b1;
									open_flag_q  <= 1'b0;
								end else begin
									out_x_q     <= '0;
									out_y_q     <= '0;
									out_value_q <= '0;
									out_min_q   <= closed_any_q ? VALUE_W'(min_q) : '0;
									out_max_q   <= VALUE_W'(max_q);
								end
							end
							OP_READ: state_q <= ST_READ_WAIT;
							OP_START: begin
								min_q        <= '1;
								max_q        <= '0;
								closed_any_q <= 1'b0;
								open_flag_q  <= 1'b0;
								integral_q   <= '0;
								clr_q        <= '0;
								state_q      <= ST_CLEAR;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DATUM_WR: state_q <= ST_IDLE;
				ST_READ_WAIT: begin
					if (out_free) begin
						out_kind_q  <= KIND_BIN;
						out_x_q     <= '0;
						out_y_q     <= '0;
						out_value_q <= VALUE_W'(rdata_q);
						out_min_q   <= closed_any_q ? VALUE_W'(min_q) : '0;
						out_max_q   <= VALUE_W'(max_q);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result_kind  = out_kind_q;
	assign closed_x     = out_x_q;
	assign closed_y     = out_y_q;
	assign value        = out_value_q;
	assign min_integral = out_min_q;
	assign max_integral = out_max_q;

endmodule
